// File: src/rotation_matrix_to_quaternion_defines.svh
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_defines
// assertion macros shared by the rotation matrix to quaternion rtl
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define RMQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define RMQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// widths, slot codes and word types of the matrix to quaternion pipeline
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int unsigned MW    = 32;	// matrix entry
	localparam int unsigned NW    = 33;	// off-diagonal sum or difference
	localparam int unsigned RW    = 36;	// radicand
	localparam int unsigned XW    = 64;	// square root and divider operands
	localparam int unsigned QW    = 32;	// quaternion component
	localparam int unsigned LANES = 3;
	localparam int unsigned STEPS = 32;

	typedef logic [1:0] slot_t;
	localparam slot_t SLOT_X = 2'd0;
	localparam slot_t SLOT_Y = 2'd1;
	localparam slot_t SLOT_Z = 2'd2;
	localparam slot_t SLOT_W = 2'd3;

	localparam logic [QW-1:0] POS_MAX = 32'h7fff_ffff;
	localparam logic [QW-1:0] NEG_MAG = 32'h8000_0000;

	typedef logic signed [MW-1:0] ent_t;
	typedef logic signed [NW-1:0] num_t;

	typedef struct packed {
		ent_t m00; ent_t m01; ent_t m02;
		ent_t m10; ent_t m11; ent_t m12;
		ent_t m20; ent_t m21; ent_t m22;
	} mat_t;

	typedef struct packed {
		logic                   invalid;
		slot_t                  sel;
		num_t [LANES-1:0]       num;
	} side_t;

	typedef struct packed {
		ent_t quat_x;
		ent_t quat_y;
		ent_t quat_z;
		ent_t quat_w;
		logic invalid;
	} word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// divider lanes take the three slots other than the one from the root
	function automatic slot_t lane_slot(input logic [1:0] lane, input slot_t sel);
		return (lane < sel) ? slot_t'(lane) : slot_t'(lane + 2'd1);
	endfunction

endpackage

// File: src/rmq_if.sv
// ----------------------------------------------------------------------------
// rmq_if
// valid/ready channels for matrix words in and quaternion words out
// ----------------------------------------------------------------------------
interface rmq_mat_if import rmq_pkg::*; ();
	logic valid;
	logic ready;
	ent_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

interface rmq_quat_if import rmq_pkg::*; ();
	logic valid;
	logic ready;
	ent_t quat_x, quat_y, quat_z, quat_w;
	logic invalid;

	modport source (output valid, quat_x, quat_y, quat_z, quat_w, invalid,
		input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, invalid,
		output ready);
endinterface

// File: src/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// trace, branch choice, radicand and divider numerators in two stages
// ----------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; #(
	parameter int unsigned FRAC_BITS = 30
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  mat_t          mat,
	output logic          out_valid,
	output logic [XW-1:0] rad,
	output side_t         side
);

	localparam logic signed [RW-1:0] ONE = RW'(1) << FRAC_BITS;

	logic signed [MW+1:0] trace_c;
	slot_t                idx_c;
	ent_t                 mii_c;
	num_t                 dif_c [3];
	num_t                 sum_c [3];

	logic                 valid_s1;
	logic signed [MW+1:0] trace_s1;
	slot_t                idx_s1;
	ent_t                 mii_s1;
	num_t                 dif_s1 [3];
	num_t                 sum_s1 [3];

	logic                 pos_c;
	logic signed [RW-1:0] r_c;
	num_t                 slot_c [4];
	slot_t                sel_c;
	side_t                side_c;
	logic [XW-1:0]        rad_c_w;

	logic                 valid_s2;
	logic [XW-1:0]        rad_s2;
	side_t                side_s2;

	always_comb begin
		trace_c = (MW+2)'(mat.m00) + (MW+2)'(mat.m11) + (MW+2)'(mat.m22);
		// strict compares pick the lower index on ties
		if (mat.m00 < mat.m11) begin
			idx_c = (mat.m11 < mat.m22) ? SLOT_Z : SLOT_Y;
		end else begin
			idx_c = (mat.m00 < mat.m22) ? SLOT_Z : SLOT_X;
		end
		case (idx_c)
			SLOT_X: mii_c = mat.m00;
			SLOT_Y: mii_c = mat.m11;
			default: mii_c = mat.m22;
		endcase
		dif_c[0] = NW'(mat.m21) - NW'(mat.m12);
		dif_c[1] = NW'(mat.m02) - NW'(mat.m20);
		dif_c[2] = NW'(mat.m10) - NW'(mat.m01);
		sum_c[0] = NW'(mat.m10) + NW'(mat.m01);
		sum_c[1] = NW'(mat.m20) + NW'(mat.m02);
		sum_c[2] = NW'(mat.m21) + NW'(mat.m12);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trace_s1 <= trace_c;
			idx_s1   <= idx_c;
			mii_s1   <= mii_c;
			dif_s1   <= dif_c;
			sum_s1   <= sum_c;
			rad_s2   <= rad_c_w;
			side_s2  <= side_c;
		end
	end

	always_comb begin
		pos_c = trace_s1 > 0;
		// m_ii - m_jj - m_kk equals 2 m_ii - trace
		r_c = pos_c ? RW'(trace_s1) + ONE
			: (RW'(mii_s1) <<< 1) - RW'(trace_s1) + ONE;
		slot_c = '{default: '0};
		if (pos_c) begin
			sel_c = SLOT_W;
			slot_c[SLOT_X] = dif_s1[0];
			slot_c[SLOT_Y] = dif_s1[1];
			slot_c[SLOT_Z] = dif_s1[2];
		end else begin
			sel_c = idx_s1;
			case (idx_s1)
				SLOT_X: begin
					slot_c[SLOT_W] = dif_s1[0];
					slot_c[SLOT_Y] = sum_s1[0];
					slot_c[SLOT_Z] = sum_s1[1];
				end
				SLOT_Y: begin
					slot_c[SLOT_W] = dif_s1[1];
					slot_c[SLOT_Z] = sum_s1[2];
					slot_c[SLOT_X] = sum_s1[0];
				end
				default: begin
					slot_c[SLOT_W] = dif_s1[2];
					slot_c[SLOT_X] = sum_s1[1];
					slot_c[SLOT_Y] = sum_s1[2];
				end
			endcase
		end
		side_c.invalid = !pos_c && (r_c <= 0);
		side_c.sel     = sel_c;
		for (int l = 0; l < LANES; l++) begin
			side_c.num[l] = slot_c[lane_slot(2'(l), sel_c)];
		end
		rad_c_w = XW'(r_c[RW-3:0]) << FRAC_BITS;
	end

	assign out_valid = valid_s2;
	assign rad       = rad_s2;
	assign side      = side_s2;

endmodule

// File: src/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// integer square root, one result bit per pipeline stage
// ----------------------------------------------------------------------------
module rmq_sqrt import rmq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [XW-1:0] rad,
	input  side_t         side_in,
	output logic          out_valid,
	output logic [QW-1:0] root,
	output side_t         side_out
);

	logic [XW-1:0] x_s    [STEPS];
	logic [XW-1:0] res_s  [STEPS];
	logic          v_s    [STEPS];
	side_t         side_s [STEPS];

	logic [XW-1:0] x_in   [STEPS];
	logic [XW-1:0] res_in [STEPS];
	logic [XW-1:0] x_nx   [STEPS];
	logic [XW-1:0] res_nx [STEPS];

	always_comb begin
		logic [XW-1:0] bitv;
		logic [XW-1:0] trial;
		x_in[0]   = rad;
		res_in[0] = '0;
		for (int t = 1; t < STEPS; t++) begin
			x_in[t]   = x_s[t-1];
			res_in[t] = res_s[t-1];
		end
		for (int t = 0; t < STEPS; t++) begin
			bitv  = XW'(1) << (XW - 2 - 2 * t);
			trial = res_in[t] + bitv;
			if (x_in[t] >= trial) begin
				x_nx[t]   = x_in[t] - trial;
				res_nx[t] = (res_in[t] >> 1) + bitv;
			end else begin
				x_nx[t]   = x_in[t];
				res_nx[t] = res_in[t] >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < STEPS; t++) v_s[t] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int t = 1; t < STEPS; t++) v_s[t] <= v_s[t-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int t = 1; t < STEPS; t++) side_s[t] <= side_s[t-1];
			for (int t = 0; t < STEPS; t++) begin
				x_s[t]   <= x_nx[t];
				res_s[t] <= res_nx[t];
			end
		end
	end

	assign out_valid = v_s[STEPS-1];
	assign root      = res_s[STEPS-1][QW-1:0];
	assign side_out  = side_s[STEPS-1];

endmodule

// File: src/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// three restoring dividers, one quotient bit per stage, then saturate and pack
// ----------------------------------------------------------------------------
module rmq_div import rmq_pkg::*; #(
	parameter int unsigned FRAC_BITS = 30
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [QW-1:0] root,
	input  side_t         side_in,
	output logic          out_valid,
	output word_t         word
);

	// set-up stage one: magnitudes and rounded dividends
	logic [XW-1:0] n_c    [LANES];
	logic          neg_c  [LANES];

	logic          v_s1;
	logic [XW-1:0] n_s1   [LANES];
	logic          neg_s1 [LANES];
	logic [QW-1:0] root_s1;
	logic          inv_s1;
	slot_t         sel_s1;

	// set-up stage two: overflow check and starting remainder
	logic [NW-1:0] dv_c;
	logic          v_s2;
	logic [NW-1:0] rem_s2 [LANES];
	logic [QW-1:0] lo_s2  [LANES];
	logic          ovf_s2 [LANES];
	logic          neg_s2 [LANES];
	logic [NW-1:0] dv_s2;
	logic [QW-2:0] half_s2;
	logic          inv_s2;
	slot_t         sel_s2;

	// divide steps
	logic          v_s    [STEPS];
	logic [NW-1:0] rem_s  [STEPS][LANES];
	logic [QW-1:0] lo_s   [STEPS][LANES];
	logic          ovf_s  [STEPS][LANES];
	logic          neg_s  [STEPS][LANES];
	logic [NW-1:0] dv_s   [STEPS];
	logic [QW-2:0] half_s [STEPS];
	logic          inv_s  [STEPS];
	slot_t         sel_s  [STEPS];

	logic [NW-1:0] rem_in [STEPS][LANES];
	logic [QW-1:0] lo_in  [STEPS][LANES];
	logic [NW-1:0] dv_in  [STEPS];
	logic [NW-1:0] rem_nx [STEPS][LANES];
	logic [QW-1:0] lo_nx  [STEPS][LANES];

	word_t         word_c;
	logic          v_s3;
	word_t         word_s3;

	always_comb begin
		logic [NW-1:0] mag;
		for (int l = 0; l < LANES; l++) begin
			neg_c[l] = side_in.num[l][NW-1];
			mag      = neg_c[l] ? NW'(-side_in.num[l]) : NW'(side_in.num[l]);
			// adding the root before dividing by twice the root rounds half up
			n_c[l]   = (XW'(mag) << FRAC_BITS) + XW'(root);
		end
	end

	assign dv_c = {root_s1, 1'b0};

	always_comb begin
		logic [NW:0] shifted;
		logic        ge;
		for (int l = 0; l < LANES; l++) begin
			rem_in[0][l] = rem_s2[l];
			lo_in[0][l]  = lo_s2[l];
		end
		dv_in[0] = dv_s2;
		for (int t = 1; t < STEPS; t++) begin
			for (int l = 0; l < LANES; l++) begin
				rem_in[t][l] = rem_s[t-1][l];
				lo_in[t][l]  = lo_s[t-1][l];
			end
			dv_in[t] = dv_s[t-1];
		end
		for (int t = 0; t < STEPS; t++) begin
			for (int l = 0; l < LANES; l++) begin
				shifted = {rem_in[t][l], lo_in[t][l][QW-1]};
				ge      = shifted >= {1'b0, dv_in[t]};
				rem_nx[t][l] = ge ? NW'(shifted - {1'b0, dv_in[t]}) : shifted[NW-1:0];
				lo_nx[t][l]  = {lo_in[t][l][QW-2:0], ge};
			end
		end
	end

	always_comb begin
		logic [QW-1:0] q;
		logic [QW-1:0] val;
		logic [QW-1:0] qv [4];
		qv = '{default: '0};
		qv[sel_s[STEPS-1]] = {1'b0, half_s[STEPS-1]};
		for (int l = 0; l < LANES; l++) begin
			q = lo_s[STEPS-1][l];
			if (neg_s[STEPS-1][l]) begin
				val = (ovf_s[STEPS-1][l] || q > NEG_MAG) ? NEG_MAG : QW'(-q);
			end else begin
				val = (ovf_s[STEPS-1][l] || q[QW-1]) ? POS_MAX : q;
			end
			qv[lane_slot(2'(l), sel_s[STEPS-1])] = val;
		end
		if (inv_s[STEPS-1]) begin
			word_c = '0;
			word_c.invalid = 1'b1;
		end else begin
			word_c.quat_x  = qv[SLOT_X];
			word_c.quat_y  = qv[SLOT_Y];
			word_c.quat_z  = qv[SLOT_Z];
			word_c.quat_w  = qv[SLOT_W];
			word_c.invalid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int t = 0; t < STEPS; t++) v_s[t] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s[0] <= v_s2;
			for (int t = 1; t < STEPS; t++) v_s[t] <= v_s[t-1];
			v_s3 <= v_s[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_s1 <= root;
			inv_s1  <= side_in.invalid;
			sel_s1  <= side_in.sel;
			for (int l = 0; l < LANES; l++) begin
				n_s1[l]   <= n_c[l];
				neg_s1[l] <= neg_c[l];
				// high word at or above the divisor means the quotient leaves 32 bits
				ovf_s2[l] <= NW'(n_s1[l][XW-2:QW]) >= dv_c;
				rem_s2[l] <= NW'(n_s1[l][XW-2:QW]);
				lo_s2[l]  <= n_s1[l][QW-1:0];
				neg_s2[l] <= neg_s1[l];
			end
			dv_s2   <= dv_c;
			half_s2 <= root_s1[QW-1:1];
			inv_s2  <= inv_s1;
			sel_s2  <= sel_s1;

			dv_s[0]   <= dv_s2;
			half_s[0] <= half_s2;
			inv_s[0]  <= inv_s2;
			sel_s[0]  <= sel_s2;
			for (int l = 0; l < LANES; l++) begin
				ovf_s[0][l] <= ovf_s2[l];
				neg_s[0][l] <= neg_s2[l];
			end
			for (int t = 1; t < STEPS; t++) begin
				dv_s[t]   <= dv_s[t-1];
				half_s[t] <= half_s[t-1];
				inv_s[t]  <= inv_s[t-1];
				sel_s[t]  <= sel_s[t-1];
				for (int l = 0; l < LANES; l++) begin
					ovf_s[t][l] <= ovf_s[t-1][l];
					neg_s[t][l] <= neg_s[t-1][l];
				end
			end
			for (int t = 0; t < STEPS; t++) begin
				for (int l = 0; l < LANES; l++) begin
					rem_s[t][l] <= rem_nx[t][l];
					lo_s[t][l]  <= lo_nx[t][l];
				end
			end
			word_s3 <= word_c;
		end
	end

	assign out_valid = v_s3;
	assign word      = word_s3;

endmodule

// File: src/rmq_ofifo.sv
// ----------------------------------------------------------------------------
// rmq_ofifo
// two-word output buffer between the pipeline and the result channel
// ----------------------------------------------------------------------------
module rmq_ofifo import rmq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  word_t      push_word,
	input  logic       pop,
	output word_t      pop_word,
	output fifo_stat_t stat
);

	word_t      mem_q [2];
	logic [1:0] cnt_q;
	logic       wp_q;
	logic       rp_q;
	logic       push_ok;
	logic       pop_ok;

	assign push_ok = push && (cnt_q != 2'd2);
	assign pop_ok  = pop && (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push_ok) wp_q <= ~wp_q;
			if (pop_ok) rp_q <= ~rp_q;
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) mem_q[wp_q] <= push_word;
	end

	assign pop_word   = mem_q[rp_q];
	assign stat.full  = cnt_q == 2'd2;
	assign stat.empty = cnt_q == 2'd0;

endmodule

// File: src/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// 3x3 rotation matrix in, unit quaternion out, trace-branch method
// ----------------------------------------------------------------------------
// mat carries one matrix word per handshake, nine signed entries with
// FRAC_BITS fraction bits; quat returns x, y, z, w in the same format plus
// invalid, which is set with all parts zero when the radicand is not positive.
// one word is taken every cycle while the output buffer is not full. the depth
// is set by the square root (one root bit per stage, 32 stages) followed by
// the dividers (one quotient bit per stage, 32 stages), with two set-up
// stages before each and a packing stage. results land in a two-word output
// buffer; the pipeline freezes only while that buffer is full, so mat.ready
// drops once two words wait there and no word is lost or repeated. reset
// clears all valid bits and the buffer; no other state is kept between words.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_defines.svh"

module rotation_matrix_to_quaternion import rmq_pkg::*; #(
	parameter int unsigned FRAC_BITS = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	rmq_mat_if.sink     mat,
	rmq_quat_if.source  quat
);

	logic          en;
	mat_t          mat_c;

	logic          fr_valid;
	logic [XW-1:0] fr_rad;
	side_t         fr_side;

	logic          sq_valid;
	logic [QW-1:0] sq_root;
	side_t         sq_side;

	logic          div_valid;
	word_t         div_word;

	word_t         pop_word;
	fifo_stat_t    stat;

	assign en        = !stat.full;
	assign mat.ready = en;

	assign mat_c.m00 = mat.m00;
	assign mat_c.m01 = mat.m01;
	assign mat_c.m02 = mat.m02;
	assign mat_c.m10 = mat.m10;
	assign mat_c.m11 = mat.m11;
	assign mat_c.m12 = mat.m12;
	assign mat_c.m20 = mat.m20;
	assign mat_c.m21 = mat.m21;
	assign mat_c.m22 = mat.m22;

	rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (mat.valid),
		.mat       (mat_c),
		.out_valid (fr_valid),
		.rad       (fr_rad),
		.side      (fr_side)
	);

	rmq_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.rad       (fr_rad),
		.side_in   (fr_side),
		.out_valid (sq_valid),
		.root      (sq_root),
		.side_out  (sq_side)
	);

	rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.root      (sq_root),
		.side_in   (sq_side),
		.out_valid (div_valid),
		.word      (div_word)
	);

	// a frozen pipeline holds its last word, so only push on an advancing cycle
	rmq_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (div_valid && en),
		.push_word (div_word),
		.pop       (quat.ready),
		.pop_word  (pop_word),
		.stat      (stat)
	);

	assign quat.valid   = !stat.empty;
	assign quat.quat_x  = pop_word.quat_x;
	assign quat.quat_y  = pop_word.quat_y;
	assign quat.quat_z  = pop_word.quat_z;
	assign quat.quat_w  = pop_word.quat_w;
	assign quat.invalid = pop_word.invalid;

	`RMQ_ASSERT_IMP(a_invalid_zero, quat.valid && quat.invalid,
		quat.quat_x == '0 && quat.quat_y == '0 && quat.quat_z == '0 && quat.quat_w == '0,
		"invalid word with non-zero quaternion")
	`RMQ_ASSERT_IMP(a_full_shows, stat.full, quat.valid,
		"full buffer without a word on offer")
	`RMQ_ASSERT_NXT(a_fill_needs_push, !stat.full && !(div_valid && en), !stat.full,
		"buffer filled without a word from the pipeline")

endmodule

// File: tb/sv/rotation_matrix_to_quaternion_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// checks matrix words in against quaternion words out, with idling and stalls
// ----------------------------------------------------------------------------
// a driver offers matrix words from a pending queue and a monitor compares
// every quaternion word with a fixed-point prediction made when its matrix
// was taken. directed corner matrices come first, then random rotations,
// signed permutations, raw noise and extremes under several idling phases.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;
	import rmq_pkg::*;

	localparam int FB       = 30;
	localparam int N_RANDOM = 2000;

	typedef struct {
		mat_t m;
		bit   drain;	// wait for every result before offering this word
	} pend_t;

	logic clk;
	logic arst_n;

	rmq_mat_if  mat_ch ();
	rmq_quat_if quat_ch ();

	rotation_matrix_to_quaternion #(.FRAC_BITS(FB)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.mat    (mat_ch),
		.quat   (quat_ch)
	);

	pend_t pending_mats[$];
	word_t expected_quats[$];
	int    n_taken = 0;
	int    n_seen = 0;
	int    n_bad = 0;
	int    n_invalid = 0;
	int    hold_left;
	bit    hold_done;
	int    send_idle_pct;
	int    recv_idle_pct;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	function automatic longint unsigned int_root(longint unsigned x);
		longint unsigned res;
		longint unsigned bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x   = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic ent_t clamp_part(longint unsigned mag, bit neg);
		if (neg) begin
			if (mag > 64'h8000_0000)
				mag = 64'h8000_0000;
			return ent_t'(-longint'(mag));
		end
		if (mag > 64'h7fff_ffff)
			mag = 64'h7fff_ffff;
		return ent_t'(mag);
	endfunction

	// d / (2 s), rounded half away from zero
	function automatic ent_t half_ratio(longint d, longint unsigned s);
		longint unsigned mag;
		mag = (d < 0) ? longint'(-d) : d;
		return clamp_part(((mag << FB) + s) / (2 * s), d < 0);
	endfunction

	function automatic word_t predict_quat(mat_t mt);
		longint e[3][3];
		longint tr;
		longint r;
		longint unsigned s;
		ent_t q[4];
		int i, j, k;
		word_t w;
		e[0][0] = mt.m00; e[0][1] = mt.m01; e[0][2] = mt.m02;
		e[1][0] = mt.m10; e[1][1] = mt.m11; e[1][2] = mt.m12;
		e[2][0] = mt.m20; e[2][1] = mt.m21; e[2][2] = mt.m22;
		tr = e[0][0] + e[1][1] + e[2][2];
		w  = '0;
		if (tr > 0) begin
			r    = tr + (longint'(1) << FB);
			s    = int_root(longint'(r) << FB);
			q[3] = clamp_part(s >> 1, 1'b0);
			q[0] = half_ratio(e[2][1] - e[1][2], s);
			q[1] = half_ratio(e[0][2] - e[2][0], s);
			q[2] = half_ratio(e[1][0] - e[0][1], s);
		end else begin
			// strict compares, so ties fall to the lower index
			if (e[0][0] < e[1][1])
				i = (e[1][1] < e[2][2]) ? 2 : 1;
			else
				i = (e[0][0] < e[2][2]) ? 2 : 0;
			j = (i + 1) % 3;
			k = (i + 2) % 3;
			r = e[i][i] - e[j][j] - e[k][k] + (longint'(1) << FB);
			if (r <= 0) begin
				w.invalid = 1'b1;
				return w;
			end
			s    = int_root(longint'(r) << FB);
			q[i] = clamp_part(s >> 1, 1'b0);
			q[3] = half_ratio(e[k][j] - e[j][k], s);
			q[j] = half_ratio(e[j][i] + e[i][j], s);
			q[k] = half_ratio(e[k][i] + e[i][k], s);
		end
		w.quat_x = q[0];
		w.quat_y = q[1];
		w.quat_z = q[2];
		w.quat_w = q[3];
		return w;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic ent_t to_fix(real v);
		real t;
		t = v * (2.0 ** FB);
		if (t > 2147483647.0)
			t = 2147483647.0;
		if (t < -2147483648.0)
			t = -2147483648.0;
		return ent_t'($rtoi(t));
	endfunction

	function automatic mat_t diag_mat(ent_t a, ent_t b, ent_t c);
		mat_t mt;
		mt     = '0;
		mt.m00 = a;
		mt.m11 = b;
		mt.m22 = c;
		return mt;
	endfunction

	function automatic ent_t rnd_ent();
		return ent_t'($urandom);
	endfunction

	function automatic mat_t rotation_mat();
		real a, b, c, d, n;
		mat_t mt;
		a = $itor($urandom_range(2000)) / 1000.0 - 1.0;
		b = $itor($urandom_range(2000)) / 1000.0 - 1.0;
		c = $itor($urandom_range(2000)) / 1000.0 - 1.0;
		d = $itor($urandom_range(2000)) / 1000.0 - 1.0;
		n = $sqrt(a * a + b * b + c * c + d * d);
		if (n < 0.001) begin
			a = 1.0;
			n = 1.0;
		end
		a = a / n; b = b / n; c = c / n; d = d / n;
		// (b, c, d) vector part, a scalar
		mt.m00 = to_fix(1.0 - 2.0 * (c * c + d * d));
		mt.m01 = to_fix(2.0 * (b * c - a * d));
		mt.m02 = to_fix(2.0 * (b * d + a * c));
		mt.m10 = to_fix(2.0 * (b * c + a * d));
		mt.m11 = to_fix(1.0 - 2.0 * (b * b + d * d));
		mt.m12 = to_fix(2.0 * (c * d - a * b));
		mt.m20 = to_fix(2.0 * (b * d - a * c));
		mt.m21 = to_fix(2.0 * (c * d + a * b));
		mt.m22 = to_fix(1.0 - 2.0 * (b * b + c * c));
		return mt;
	endfunction

	// signed permutation with small noise, can land on either trace branch
	function automatic mat_t perm_mat();
		ent_t e[9];
		int p;
		mat_t mt;
		p = $urandom_range(2);
		foreach (e[n])
			e[n] = ent_t'($signed($urandom_range(4095)) - 2048);
		for (int r = 0; r < 3; r++)
			e[r * 3 + ((r + p) % 3)] += ($urandom_range(1)) ? to_fix(1.0) : to_fix(-1.0);
		mt = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
		return mt;
	endfunction

	function automatic mat_t extreme_mat();
		ent_t e[9];
		mat_t mt;
		foreach (e[n])
			case ($urandom_range(3))
				0: e[n] = ent_t'(32'h8000_0000);
				1: e[n] = ent_t'(32'h7fff_ffff);
				2: e[n] = '0;
				default: e[n] = to_fix(1.0);
			endcase
		mt = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
		return mt;
	endfunction

	function automatic mat_t noise_mat();
		return {rnd_ent(), rnd_ent(), rnd_ent(), rnd_ent(), rnd_ent(),
			rnd_ent(), rnd_ent(), rnd_ent(), rnd_ent()};
	endfunction

	task automatic queue_mat(mat_t mt, bit drain);
		pend_t p;
		p.m     = mt;
		p.drain = drain;
		pending_mats.insert(pending_mats.size(), p);
	endtask

	// ------------------------------------------------------------------
	// driver: matrix words change on the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_ch.valid <= 1'b0;
			{mat_ch.m00, mat_ch.m01, mat_ch.m02, mat_ch.m10, mat_ch.m11,
				mat_ch.m12, mat_ch.m20, mat_ch.m21, mat_ch.m22} <= '0;
		end else if (mat_ch.valid && !mat_ch.ready) begin
			// word still on offer
		end else if (pending_mats.size() != 0
				&& !(pending_mats[0].drain && expected_quats.size() != 0)
				&& $urandom_range(99) >= send_idle_pct) begin
			pend_t p;
			p = pending_mats.pop_front();
			mat_ch.valid <= 1'b1;
			{mat_ch.m00, mat_ch.m01, mat_ch.m02, mat_ch.m10, mat_ch.m11,
				mat_ch.m12, mat_ch.m20, mat_ch.m21, mat_ch.m22} <= p.m;
		end else begin
			mat_ch.valid <= 1'b0;
		end
	end

	// long receiver hold-off, started once the random part is under way
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_taken >= 600) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			quat_ch.ready <= 1'b0;
		else
			quat_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
	end

	// idling phases change every 250 words taken
	always @(negedge clk) begin
		case ((n_taken / 250) % 4)
			0: begin send_idle_pct <= 0;  recv_idle_pct <= 0;  end
			1: begin send_idle_pct <= 58; recv_idle_pct <= 0;  end
			2: begin send_idle_pct <= 0;  recv_idle_pct <= 58; end
			default: begin send_idle_pct <= 16; recv_idle_pct <= 16; end
		endcase
	end

	// ------------------------------------------------------------------
	// monitor: both channels sampled on the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && mat_ch.valid && mat_ch.ready) begin
			mat_t mt;
			mt = {mat_ch.m00, mat_ch.m01, mat_ch.m02, mat_ch.m10, mat_ch.m11,
				mat_ch.m12, mat_ch.m20, mat_ch.m21, mat_ch.m22};
			expected_quats.insert(expected_quats.size(), predict_quat(mt));
			n_taken++;
		end
		if (arst_n && quat_ch.valid && quat_ch.ready) begin
			word_t got, want;
			got = {quat_ch.quat_x, quat_ch.quat_y, quat_ch.quat_z,
				quat_ch.quat_w, quat_ch.invalid};
			n_seen++;
			if (expected_quats.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected word %0d: x=%h y=%h z=%h w=%h inv=%b", n_seen,
						got.quat_x, got.quat_y, got.quat_z, got.quat_w, got.invalid);
			end else begin
				want = expected_quats.pop_front();
				if (want.invalid)
					n_invalid++;
				if (got !== want) begin
					n_bad++;
					if (n_bad <= 10)
						$display("word %0d mismatch: x %h/%h y %h/%h z %h/%h w %h/%h inv %b/%b",
							n_seen, want.quat_x, got.quat_x, want.quat_y, got.quat_y,
							want.quat_z, got.quat_z, want.quat_w, got.quat_w,
							want.invalid, got.invalid);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		ent_t one_f, mn, mx;
		one_f = to_fix(1.0);
		mn    = ent_t'(32'h8000_0000);
		mx    = ent_t'(32'h7fff_ffff);

		// identity and the three half-turns
		queue_mat(diag_mat(one_f, one_f, one_f), 1'b0);
		queue_mat(diag_mat(one_f, -one_f, -one_f), 1'b0);
		queue_mat(diag_mat(-one_f, one_f, -one_f), 1'b0);
		queue_mat(diag_mat(-one_f, -one_f, one_f), 1'b0);
		// zero trace, equal diagonals, ties between pairs
		queue_mat('0, 1'b0);
		queue_mat(diag_mat(-one_f, -one_f, -one_f), 1'b0);
		queue_mat(diag_mat(-one_f, -one_f, -one_f / 2), 1'b0);
		queue_mat(diag_mat(-one_f / 2, -one_f / 2, -one_f), 1'b0);
		queue_mat(diag_mat(-one_f / 2, -one_f, -one_f / 2), 1'b0);
		// diagonals at the field extremes
		queue_mat(diag_mat(mn, mn, mn), 1'b0);
		queue_mat(diag_mat(mn, mx, mx), 1'b0);
		// field extremes, saturation of the ratios
		queue_mat({9{mx}}, 1'b0);
		queue_mat({9{mn}}, 1'b0);
		queue_mat({ent_t'(1), mn, mx, mx, ent_t'(1), mn, mn, mx, ent_t'(1)}, 1'b0);
		queue_mat({ent_t'(0), mx, mn, mn, ent_t'(0), mx, mx, mn, ent_t'(0)}, 1'b0);
		queue_mat({-one_f, mx, mx, mx, -one_f, mx, mx, mx, mn}, 1'b0);
		queue_mat({ent_t'(-1), mn, mn, mn, ent_t'(-1), mn, mn, mn, ent_t'(-1)}, 1'b0);
		queue_mat({ent_t'(1), ent_t'(0), ent_t'(0), ent_t'(0), ent_t'(0),
			ent_t'(0), ent_t'(0), ent_t'(0), ent_t'(0)}, 1'b0);
		queue_mat(diag_mat(ent_t'(-(32'sd1 << 30) + 1), ent_t'(0), ent_t'(0)), 1'b0);

		for (int n = 0; n < N_RANDOM; n++) begin
			int pick;
			mat_t mt;
			pick = $urandom_range(99);
			if (pick < 50)
				mt = rotation_mat();
			else if (pick < 68)
				mt = perm_mat();
			else if (pick < 90)
				mt = noise_mat();
			else
				mt = extreme_mat();
			// the sender waits for a full drain at the start and once midway
			queue_mat(mt, n == 0 || n == N_RANDOM / 2);
		end

		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_mats.size() == 0);
		@(posedge clk);
		while (mat_ch.valid || expected_quats.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("%0d matrices taken, %0d quaternions checked, %0d flagged invalid, %0d mismatches",
			n_taken, n_seen, n_invalid, n_bad);
		$display("covered positive and non-positive trace branches, ties and saturation");
		if (n_bad == 0 && expected_quats.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5ms;
		$display("timed out with %0d words outstanding", expected_quats.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
